// ===== hdl/mcl_pkg.sv =====
package mcl_pkg;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] OP_KERNEL  = 2'd0;
	localparam logic [1:0] OP_PIXEL   = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// Field widths of the stream items.
	localparam int COL_W    = 8;
	localparam int ROW_W    = 2;
	localparam int CHAN_W   = 2;
	localparam int VALUE_W  = 16;
	localparam int LINE_W   = 10;
	localparam int SUM_W    = 32;
	localparam int IMG_W_W  = 9;
	localparam int IMG_H_W  = 11;
	localparam int CFG_W    = 11;

	// Signed tap coordinates: column and image row with room for the kernel offset.
	localparam int SX_W     = COL_W + 3;
	localparam int IROW_W   = LINE_W + 2;

	// Saturation limits of the result.
	localparam logic [SUM_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
	localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} mcl_state_t;

	// One tap handed from the sequencer to the multiply-accumulate datapath.
	typedef struct packed {
		logic clr;
		logic vld;
		logic hit;
	} mcl_issue_t;

	// Store write strobes.
	typedef struct packed {
		logic kern;
		logic band;
	} mcl_wr_t;

endpackage

// ===== hdl/mcl_dp.sv =====
module mcl_dp #(
	parameter int KERNEL_W  = 3,
	parameter int KERNEL_H  = 3,
	parameter int CHANNELS  = 3,
	parameter int MAX_WIDTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mcl_pkg::mcl_issue_t                 issue,
	input  logic [$clog2(MAX_WIDTH*KERNEL_H*CHANNELS)-1:0] band_raddr,
	input  logic [((KERNEL_W*KERNEL_H*CHANNELS > 1) ?
		$clog2(KERNEL_W*KERNEL_H*CHANNELS) : 1)-1:0]        kern_raddr,
	input  mcl_pkg::mcl_wr_t                    wr,
	input  logic [$clog2(MAX_WIDTH*KERNEL_H*CHANNELS)-1:0] band_waddr,
	input  logic [((KERNEL_W*KERNEL_H*CHANNELS > 1) ?
		$clog2(KERNEL_W*KERNEL_H*CHANNELS) : 1)-1:0]        kern_waddr,
	input  logic signed [mcl_pkg::VALUE_W-1:0]  wdata,
	output logic                                pipe_busy,
	output logic [mcl_pkg::SUM_W-1:0]           sum
);
	import mcl_pkg::*;

	localparam int KSIZE  = KERNEL_W * KERNEL_H * CHANNELS;
	localparam int BSIZE  = MAX_WIDTH * KERNEL_H * CHANNELS;
	localparam int ACC_W  = SUM_W + 1 + $clog2(KSIZE);

	logic signed [VALUE_W-1:0] kern_mem [KSIZE];
	logic signed [VALUE_W-1:0] band_mem [BSIZE];

	logic signed [VALUE_W-1:0] kern_rd_s1;
	logic signed [VALUE_W-1:0] band_rd_s1;
	logic                      vld_s1;
	logic                      hit_s1;
	logic signed [SUM_W-1:0]   prod_s2;
	logic                      vld_s2;
	logic                      hit_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      ovf;

	// Kernel coefficient store with a registered read port.
	always_ff @(posedge clk) begin
		if (wr.kern) begin
			kern_mem[kern_waddr] <= wdata;
		end
		kern_rd_s1 <= kern_mem[kern_raddr];
	end

	// Line band store with a registered read port.
	always_ff @(posedge clk) begin
		if (wr.band) begin
			band_mem[band_waddr] <= wdata;
		end
		band_rd_s1 <= band_mem[band_raddr];
	end

	// The shared multiplier: one tap product per cycle.
	always_ff @(posedge clk) begin
		prod_s2 <= kern_rd_s1 * band_rd_s1;
	end

	// Tap flags follow the data through the read and multiply stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			hit_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			hit_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue.vld;
			hit_s1 <= issue.hit;
			vld_s2 <= vld_s1;
			hit_s2 <= hit_s1;
		end
	end

	// Exact accumulation; clipped taps add nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (issue.clr) begin
			acc_q <= '0;
		end else if (vld_s2 && hit_s2) begin
			acc_q <= acc_q + {{(ACC_W-SUM_W){prod_s2[SUM_W-1]}}, prod_s2};
		end
	end

	assign pipe_busy = vld_s1 | vld_s2;

	// Saturate to 32 bits: overflow when the bits above bit 31 are not all sign copies.
	assign ovf = (acc_q[ACC_W-1:SUM_W-1] != '0) && (acc_q[ACC_W-1:SUM_W-1] != '1);

	always_comb begin
		if (!ovf) begin
			sum = acc_q[SUM_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			sum = SUM_MIN;
		end else begin
			sum = SUM_MAX;
		end
	end

endmodule

// ===== hdl/mcl_seq.sv =====
module mcl_seq #(
	parameter int KERNEL_W  = 3,
	parameter int KERNEL_H  = 3,
	parameter int CHANNELS  = 3,
	parameter int MAX_WIDTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	output logic                                in_rdy,
	input  logic [1:0]                          op,
	input  logic [mcl_pkg::COL_W-1:0]           col,
	input  logic [mcl_pkg::ROW_W-1:0]           row,
	input  logic [mcl_pkg::ROW_W-1:0]           kcol,
	input  logic [mcl_pkg::CHAN_W-1:0]          chan,
	input  logic [mcl_pkg::LINE_W-1:0]          line,
	input  logic [mcl_pkg::IMG_W_W-1:0]         image_width,
	input  logic [mcl_pkg::IMG_H_W-1:0]         image_height,
	input  logic                                pipe_busy,
	input  logic                                out_free,
	output mcl_pkg::mcl_issue_t                 issue,
	output logic [$clog2(MAX_WIDTH*KERNEL_H*CHANNELS)-1:0] band_raddr,
	output logic [((KERNEL_W*KERNEL_H*CHANNELS > 1) ?
		$clog2(KERNEL_W*KERNEL_H*CHANNELS) : 1)-1:0]        kern_raddr,
	output mcl_pkg::mcl_wr_t                    wr,
	output logic [$clog2(MAX_WIDTH*KERNEL_H*CHANNELS)-1:0] band_waddr,
	output logic [((KERNEL_W*KERNEL_H*CHANNELS > 1) ?
		$clog2(KERNEL_W*KERNEL_H*CHANNELS) : 1)-1:0]        kern_waddr,
	output logic                                load_out,
	output logic                                last
);
	import mcl_pkg::*;

	localparam int KSIZE  = KERNEL_W * KERNEL_H * CHANNELS;
	localparam int BSIZE  = MAX_WIDTH * KERNEL_H * CHANNELS;
	localparam int KAW    = (KSIZE > 1) ? $clog2(KSIZE) : 1;
	localparam int BAW    = $clog2(BSIZE);
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int KCW    = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;
	localparam int RCW    = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
	localparam int CCW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HALF_W = KERNEL_W / 2;
	localparam int HALF_H = KERNEL_H / 2;

	mcl_state_t         state_q;
	mcl_state_t         state_d;
	logic [KCW-1:0]     k_q;
	logic [RCW-1:0]     r_q;
	logic [CCW-1:0]     c_q;
	logic [COL_W-1:0]   col_q;
	logic [LINE_W-1:0]  line_q;
	logic               last_q;
	logic               accept;
	logic               start;
	logic               k_end;
	logic               r_end;
	logic               c_end;
	logic [SX_W-1:0]    sx;
	logic [IROW_W-1:0]  irow;
	logic               col_in;
	logic               row_in;

	assign accept = in_vld && in_rdy;
	assign start  = accept && (op == OP_COMPUTE);
	assign k_end  = (k_q == KCW'(KERNEL_W - 1));
	assign r_end  = (r_q == RCW'(KERNEL_H - 1));
	assign c_end  = (c_q == CCW'(CHANNELS - 1));

	// Store writes happen at the edge that accepts the item; bad indexes are dropped.
	always_comb begin
		wr.kern = accept && (op == OP_KERNEL) && (32'(row) < KERNEL_H) &&
			(32'(kcol) < KERNEL_W) && (32'(chan) < CHANNELS);
		wr.band = accept && (op == OP_PIXEL) && (32'(col) < MAX_WIDTH) &&
			(32'(row) < KERNEL_H) && (32'(chan) < CHANNELS);
		kern_waddr = KAW'(((KERNEL_H - 1 - 32'(row)) * KERNEL_W +
			(KERNEL_W - 1 - 32'(kcol))) * CHANNELS + 32'(chan));
		band_waddr = BAW'((32'(col) * KERNEL_H + 32'(row)) * CHANNELS + 32'(chan));
	end

	// Tap position and clipping for the current counter values.
	always_comb begin
		sx   = SX_W'(col_q) - SX_W'(HALF_W) + SX_W'(k_q);
		irow = IROW_W'(line_q) - IROW_W'(HALF_H) + IROW_W'(r_q);
		col_in = !sx[SX_W-1] && (sx[SX_W-2:0] < (SX_W-1)'(image_width)) &&
			(32'(sx[SX_W-2:0]) < MAX_WIDTH);
		row_in = !irow[IROW_W-1] && (irow[IROW_W-2:0] < image_height);
		band_raddr = BAW'((32'(sx[CW-1:0]) * KERNEL_H + 32'(r_q)) * CHANNELS + 32'(c_q));
		kern_raddr = KAW'((32'(r_q) * KERNEL_W + 32'(k_q)) * CHANNELS + 32'(c_q));
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Tap counters: kernel column fastest, then kernel row, then channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			r_q <= '0;
			c_q <= '0;
		end else if (start) begin
			k_q <= '0;
			r_q <= '0;
			c_q <= '0;
		end else if (state_q == ST_RUN) begin
			if (!k_end) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
				if (!r_end) begin
					r_q <= r_q + 1'b1;
				end else begin
					r_q <= '0;
					c_q <= c_end ? '0 : c_q + 1'b1;
				end
			end
		end
	end

	// Held fields of the pixel being computed.
	always_ff @(posedge clk) begin
		if (start) begin
			col_q  <= col;
			line_q <= line;
			last_q <= (image_width != '0) && ({1'b0, col} == image_width - 1'b1);
		end
	end

	assign last = last_q;

	// Next state and strobes.
	always_comb begin
		state_d   = state_q;
		in_rdy    = 1'b0;
		issue.clr = start;
		issue.vld = 1'b0;
		issue.hit = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (start) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue.vld = 1'b1;
				issue.hit = col_in && row_in;
				if (k_end && r_end && c_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pipe_busy && out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/multichannel_conv_line.sv =====
// Zero-padded multichannel convolution, one output pixel per compute item.
// Kernel-write (tuser 0) and band-pixel-write (tuser 1) items are written
// as they are accepted. A compute item (tuser 2) walks all
// KERNEL_W*KERNEL_H*CHANNELS taps through one shared 16x16 multiplier and
// one accumulator, one tap per cycle. After the taps the read and multiply
// stages drain, the output register loads and the sequencer goes back to
// idle, and only there is the input ready again. The load waits while an
// earlier result is still held in the output register. Taps outside the
// image columns or rows add nothing, and the result is saturated to signed
// 32 bits. The result sits in an output register, so the next item can be
// taken while it waits.
// Neither store is cleared by reset: write the kernel and the band before
// computing. Unused tuser code 3 is accepted and does nothing.
module multichannel_conv_line #(
	parameter int KERNEL_W  = 3,
	parameter int KERNEL_H  = 3,
	parameter int CHANNELS  = 3,
	parameter int MAX_WIDTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write port.
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mcl_pkg::CFG_W-1:0]   cfg_data,
	// Input stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [39:0]                 s_tdata,  // col, row, kcol, chan, value, line
	input  logic [1:0]                  s_tuser,  // op
	// Result stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,  // sum
	output logic                        m_tlast   // last
);
	import mcl_pkg::*;

	localparam int KSIZE = KERNEL_W * KERNEL_H * CHANNELS;
	localparam int KAW   = (KSIZE > 1) ? $clog2(KSIZE) : 1;
	localparam int BAW   = $clog2(MAX_WIDTH * KERNEL_H * CHANNELS);

	logic [IMG_W_W-1:0]         image_width_q;
	logic [IMG_H_W-1:0]         image_height_q;
	logic [COL_W-1:0]           col;
	logic [ROW_W-1:0]           row;
	logic [ROW_W-1:0]           kcol;
	logic [CHAN_W-1:0]          chan;
	logic signed [VALUE_W-1:0]  value;
	logic [LINE_W-1:0]          line;
	mcl_issue_t                 issue;
	mcl_wr_t                    wr;
	logic [BAW-1:0]             band_raddr;
	logic [BAW-1:0]             band_waddr;
	logic [KAW-1:0]             kern_raddr;
	logic [KAW-1:0]             kern_waddr;
	logic                       pipe_busy;
	logic                       out_free;
	logic                       load_out;
	logic                       last;
	logic [SUM_W-1:0]           sum;
	logic                       m_tvalid_q;
	logic [SUM_W-1:0]           m_tdata_q;
	logic                       m_tlast_q;

	// Unpack the input item.
	assign col   = s_tdata[7:0];
	assign row   = s_tdata[9:8];
	assign kcol  = s_tdata[11:10];
	assign chan  = s_tdata[13:12];
	assign value = s_tdata[29:14];
	assign line  = s_tdata[39:30];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 9'd256;
			image_height_q <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[IMG_H_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mcl_seq #(
		.KERNEL_W  (KERNEL_W),
		.KERNEL_H  (KERNEL_H),
		.CHANNELS  (CHANNELS),
		.MAX_WIDTH (MAX_WIDTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (s_tvalid),
		.in_rdy       (s_tready),
		.op           (s_tuser),
		.col          (col),
		.row          (row),
		.kcol         (kcol),
		.chan         (chan),
		.line         (line),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.pipe_busy    (pipe_busy),
		.out_free     (out_free),
		.issue        (issue),
		.band_raddr   (band_raddr),
		.kern_raddr   (kern_raddr),
		.wr           (wr),
		.band_waddr   (band_waddr),
		.kern_waddr   (kern_waddr),
		.load_out     (load_out),
		.last         (last)
	);

	mcl_dp #(
		.KERNEL_W  (KERNEL_W),
		.KERNEL_H  (KERNEL_H),
		.CHANNELS  (CHANNELS),
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.band_raddr (band_raddr),
		.kern_raddr (kern_raddr),
		.wr         (wr),
		.band_waddr (band_waddr),
		.kern_waddr (kern_waddr),
		.wdata      (value),
		.pipe_busy  (pipe_busy),
		.sum        (sum)
	);

	// Output register; a new result may load in the cycle the old one leaves.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= sum;
			m_tlast_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== hdl/mcl_chk.sv =====
module mcl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);
	import mcl_pkg::*;

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// A compute item occupies the block: the input is not ready in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_COMPUTE) |=> !s_tready)
		else $error("input ready right after a compute item");

	// Store writes and unused codes finish at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != OP_COMPUTE) |=> s_tready)
		else $error("input not ready after a write item");

	// No result can come out of the tap pipeline early, right after the start.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_COMPUTE) |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
		else $error("result appeared too early");

endmodule

bind multichannel_conv_line mcl_chk u_chk (.*);
